// ----- rtl/tdc_inl_correct_hit_pairing_top_defines.svh -----
// Assertion macros for the block's modules; only the sequencer uses them.
// Each expects signals named clk and rst_n in the module that uses it.
`ifndef TDC_INL_CORRECT_HIT_PAIRING_TOP_DEFINES_SVH
`define TDC_INL_CORRECT_HIT_PAIRING_TOP_DEFINES_SVH

// Same-cycle implication.
`define TDC_IHP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TDC_IHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tdc_ihp_pkg.sv -----
package tdc_ihp_pkg;

    localparam int CORR_BINS_DEF    = 1024;
    localparam int NUM_CHANNELS_DEF = 72;
    localparam int NUM_KEYS_DEF     = 1024;

    localparam int MODE_W  = 2;
    localparam int CH_W    = 7;
    localparam int BIN_W   = 10;
    localparam int CORR_W  = 16;
    localparam int RAW_W   = 21;
    localparam int KEY_W   = 10;
    localparam int TIME_W  = 48;
    localparam int BWID_W  = 24;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Q8 time arithmetic
    localparam int FRAC_W     = 8;
    localparam int Q_W        = RAW_W + FRAC_W + 2;
    localparam int PROD_W     = Q_W + BWID_W + 1;
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);

    localparam logic signed [TIME_W-1:0] T48_MAX = {1'b0, {(TIME_W-1){1'b1}}};

    localparam logic              USE_CORR_RST  = 1'b1;
    localparam logic [BWID_W-1:0] BIN_WIDTH_RST = 24'd97656;

    // register index is paddr[2]
    typedef enum logic [0:0] {
        REG_USE_CORR  = 1'b0,
        REG_BIN_WIDTH = 1'b1
    } reg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_HIT   = 2'd1,
        MODE_DRAIN = 2'd2
    } item_mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_FIX,
        ST_LOOKUP,
        ST_QSUM,
        ST_MULT,
        ST_ROUND,
        ST_UPDATE,
        ST_DRAIN
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic div_en;
        logic rem_en;
        logic fix_en;
        logic lookup_en;
        logic qsum_en;
        logic mult_en;
        logic round_en;
        logic update_en;
        logic drain_en;
        logic clear_en;
    } ihp_cmd_t;

    typedef struct packed {
        logic is_hit;
        logic is_drain;
        logic key_ok;
        logic out_free;
        logic clear_last;
    } ihp_status_t;

    typedef struct packed {
        logic                     lead_seen;
        logic                     trail_seen;
        logic signed [TIME_W-1:0] lead_min;
        logic signed [TIME_W-1:0] trail_min;
    } key_entry_t;

    localparam key_entry_t KEY_EMPTY = '{1'b0, 1'b0, T48_MAX, T48_MAX};

endpackage

// ----- rtl/tdc_ihp_cfg.sv -----
module tdc_ihp_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tdc_ihp_pkg::APB_AW-1:0]   paddr,
    input  logic [tdc_ihp_pkg::APB_DW-1:0]   pwdata,
    output logic [tdc_ihp_pkg::APB_DW-1:0]   prdata,
    output logic                             pready,
    output logic                             use_correction,
    output logic [tdc_ihp_pkg::BWID_W-1:0]   bin_width_fs
);
    import tdc_ihp_pkg::*;

    logic              use_corr_reg;
    logic [BWID_W-1:0] bin_width_reg;
    logic              wr_en;
    reg_index_t        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_corr_reg  <= USE_CORR_RST;
            bin_width_reg <= BIN_WIDTH_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_USE_CORR:  use_corr_reg  <= pwdata[0];
                REG_BIN_WIDTH: bin_width_reg <= pwdata[BWID_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_USE_CORR:  prdata = APB_DW'(use_corr_reg);
            REG_BIN_WIDTH: prdata = APB_DW'(bin_width_reg);
            default:       prdata = '0;
        endcase
    end

    assign use_correction = use_corr_reg;
    assign bin_width_fs   = bin_width_reg;

endmodule

// ----- rtl/tdc_ihp_ctrl.sv -----
`include "tdc_inl_correct_hit_pairing_top_defines.svh"

module tdc_ihp_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  tdc_ihp_pkg::ihp_status_t status,
    output tdc_ihp_pkg::ihp_cmd_t    cmd
);
    import tdc_ihp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_en = 1'b1;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                cmd.rem_en = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix_en = 1'b1;
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                // loads finish here; hits and drains continue on a valid key
                cmd.lookup_en = 1'b1;
                if (status.is_hit && status.key_ok)
                begin
                    state_next = ST_QSUM;
                end
                else if (status.is_drain && status.key_ok)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QSUM:
            begin
                cmd.qsum_en = 1'b1;
                state_next  = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult_en = 1'b1;
                state_next  = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update_en = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_DRAIN:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.drain_en = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `TDC_IHP_ASSERT_NEXT(a_accept_starts_div, in_valid && in_ready, state_reg == ST_DIV,
        "accepted item did not start sequencing")
    `TDC_IHP_ASSERT_NEXT(a_drain_holds, (state_reg == ST_DRAIN) && !status.out_free,
        state_reg == ST_DRAIN, "drain left while output register was full")
    `TDC_IHP_ASSERT_NEXT(a_clear_ends_idle, (state_reg == ST_CLEAR) && status.clear_last,
        state_reg == ST_IDLE, "clear pass did not end in idle")
    `TDC_IHP_ASSERT_NOW(a_mult_after_qsum, state_reg == ST_MULT,
        $past(state_reg) == ST_QSUM, "multiply step entered out of order")

endmodule

// ----- rtl/tdc_ihp_datapath.sv -----
module tdc_ihp_datapath #(
    parameter int CORR_BINS    = tdc_ihp_pkg::CORR_BINS_DEF,
    parameter int NUM_CHANNELS = tdc_ihp_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_KEYS     = tdc_ihp_pkg::NUM_KEYS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tdc_ihp_pkg::ihp_cmd_t                  cmd,
    output tdc_ihp_pkg::ihp_status_t               status,
    input  logic                                   use_correction,
    input  logic [tdc_ihp_pkg::BWID_W-1:0]         bin_width_fs,
    input  logic [tdc_ihp_pkg::MODE_W-1:0]         mode,
    input  logic [tdc_ihp_pkg::CH_W-1:0]           channel,
    input  logic [tdc_ihp_pkg::BIN_W-1:0]          corr_bin,
    input  logic signed [tdc_ihp_pkg::CORR_W-1:0]  corr_value,
    input  logic                                   corr_last,
    input  logic [tdc_ihp_pkg::RAW_W-1:0]          raw_time,
    input  logic                                   leading,
    input  logic [tdc_ihp_pkg::KEY_W-1:0]          key_index,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [tdc_ihp_pkg::KEY_W-1:0]          out_key,
    output logic signed [tdc_ihp_pkg::TIME_W-1:0]  lead_time_fs,
    output logic signed [tdc_ihp_pkg::TIME_W-1:0]  width_fs
);
    import tdc_ihp_pkg::*;

    localparam int CORR_DEPTH = NUM_CHANNELS * CORR_BINS;
    localparam int CORR_AW    = $clog2(CORR_DEPTH);
    localparam int KEY_AW     = $clog2(NUM_KEYS);
    localparam int CH_AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CB_W       = $clog2(CORR_BINS) + 1;
    // floor(2^RAW_W / CORR_BINS): the quotient estimate is short by at most one
    localparam int DIV_M      = (1 << RAW_W) / CORR_BINS;
    localparam int M_W        = RAW_W - $clog2(CORR_BINS) + 1;

    // captured item
    logic [MODE_W-1:0]        mode_reg;
    logic [CH_W-1:0]          channel_reg;
    logic [BIN_W-1:0]         corr_bin_reg;
    logic signed [CORR_W-1:0] corr_value_reg;
    logic                     corr_last_reg;
    logic [RAW_W-1:0]         raw_time_reg;
    logic                     leading_reg;
    logic [KEY_W-1:0]         key_index_reg;

    // bin address arithmetic
    logic [RAW_W+M_W-1:0]     div_prod;
    logic [M_W-1:0]           quot_reg;
    logic [M_W+CB_W-1:0]      qc_full;
    logic [RAW_W-1:0]         qc_reg;
    logic [CH_W+CB_W-1:0]     base_full;
    logic [CORR_AW-1:0]       base_reg;
    logic [RAW_W-1:0]         diff;
    logic [RAW_W-1:0]         diff_c;
    logic [RAW_W-1:0]         rem;
    logic [CORR_AW-1:0]       bin_sel;
    logic [CORR_AW-1:0]       corr_addr_reg;

    // correction store and channel flags
    logic signed [CORR_W-1:0] corr_mem [CORR_DEPTH];
    logic signed [CORR_W-1:0] corr_rd_reg;
    logic [NUM_CHANNELS-1:0]  ready_reg;
    logic                     apply_reg;
    logic                     is_load;
    logic                     ch_ok;
    logic                     bin_ok;
    logic [CH_AW-1:0]         ch_idx;
    logic                     corr_wr_en;

    // time arithmetic
    logic signed [Q_W-1:0]    q_reg;
    logic signed [BWID_W:0]   bw_s;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] rnd_sum;
    logic signed [TIME_W-1:0] t_reg;

    // key store
    key_entry_t               key_mem [NUM_KEYS];
    key_entry_t               key_rd_reg;
    key_entry_t               upd_entry;
    key_entry_t               key_wr_data;
    logic [KEY_AW-1:0]        key_addr;
    logic [KEY_AW-1:0]        key_wr_addr;
    logic                     key_wr_en;
    logic [KEY_AW-1:0]        clr_cnt_reg;
    logic                     pair_ok;

    // output register
    logic                     out_valid_reg;
    logic [KEY_W-1:0]         out_key_reg;
    logic signed [TIME_W-1:0] lead_time_reg;
    logic signed [TIME_W-1:0] width_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg       <= mode;
            channel_reg    <= channel;
            corr_bin_reg   <= corr_bin;
            corr_value_reg <= corr_value;
            corr_last_reg  <= corr_last;
            raw_time_reg   <= raw_time;
            leading_reg    <= leading;
            key_index_reg  <= key_index;
        end
    end

    assign is_load = (mode_reg == MODE_LOAD);
    assign ch_ok   = int'(channel_reg) < NUM_CHANNELS;
    assign bin_ok  = int'(corr_bin_reg) < CORR_BINS;
    assign ch_idx  = CH_AW'(channel_reg);
    assign key_addr = KEY_AW'(key_index_reg);

    assign status.is_hit     = (mode_reg == MODE_HIT);
    assign status.is_drain   = (mode_reg == MODE_DRAIN);
    assign status.key_ok     = int'(key_index_reg) < NUM_KEYS;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.clear_last = (clr_cnt_reg == KEY_AW'(NUM_KEYS - 1));

    // raw mod CORR_BINS by reciprocal multiply, then one correction step
    assign div_prod  = raw_time_reg * M_W'(DIV_M);
    assign qc_full   = quot_reg * CB_W'(CORR_BINS);
    assign base_full = channel_reg * CB_W'(CORR_BINS);
    assign diff      = raw_time_reg - qc_reg;
    assign diff_c    = diff - RAW_W'(CORR_BINS);
    assign rem       = (diff >= RAW_W'(CORR_BINS)) ? diff_c : diff;
    assign bin_sel   = is_load ? CORR_AW'(corr_bin_reg) : CORR_AW'(rem);

    always_ff @(posedge clk)
    begin
        if (cmd.div_en)
        begin
            quot_reg <= div_prod[RAW_W +: M_W];
        end
        if (cmd.rem_en)
        begin
            qc_reg   <= qc_full[RAW_W-1:0];
            base_reg <= CORR_AW'(base_full);
        end
        if (cmd.fix_en)
        begin
            corr_addr_reg <= base_reg + bin_sel;
        end
    end

    assign corr_wr_en = cmd.lookup_en && is_load && ch_ok && bin_ok;

    always_ff @(posedge clk)
    begin
        if (corr_wr_en)
        begin
            corr_mem[corr_addr_reg] <= corr_value_reg;
        end
        if (cmd.lookup_en)
        begin
            corr_rd_reg <= corr_mem[corr_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= '0;
        end
        else if (cmd.lookup_en && is_load && ch_ok)
        begin
            ready_reg[ch_idx] <= corr_last_reg;
        end
    end

    assign bw_s    = $signed({1'b0, bin_width_fs});
    assign rnd_sum = prod_reg + PROD_W'(ROUND_HALF);

    always_ff @(posedge clk)
    begin
        if (cmd.lookup_en)
        begin
            apply_reg <= use_correction && ch_ok && ready_reg[ch_idx];
        end
        if (cmd.qsum_en)
        begin
            q_reg <= $signed({2'b00, raw_time_reg, {FRAC_W{1'b0}}})
                   + (apply_reg ? Q_W'(corr_rd_reg) : Q_W'(0));
        end
        if (cmd.mult_en)
        begin
            prod_reg <= q_reg * bw_s;
        end
        if (cmd.round_en)
        begin
            // arithmetic floor of (p + 128) / 256
            t_reg <= rnd_sum[FRAC_W +: TIME_W];
        end
    end

    always_comb
    begin
        upd_entry = key_rd_reg;
        if (leading_reg)
        begin
            upd_entry.lead_seen = 1'b1;
            if (!key_rd_reg.lead_seen || (t_reg < key_rd_reg.lead_min))
            begin
                upd_entry.lead_min = t_reg;
            end
        end
        else
        begin
            upd_entry.trail_seen = 1'b1;
            if (!key_rd_reg.trail_seen || (t_reg < key_rd_reg.trail_min))
            begin
                upd_entry.trail_min = t_reg;
            end
        end
    end

    assign key_wr_en   = cmd.clear_en || cmd.update_en || cmd.drain_en;
    assign key_wr_addr = cmd.clear_en ? clr_cnt_reg : key_addr;
    assign key_wr_data = cmd.update_en ? upd_entry : KEY_EMPTY;

    always_ff @(posedge clk)
    begin
        if (key_wr_en)
        begin
            key_mem[key_wr_addr] <= key_wr_data;
        end
        if (cmd.lookup_en)
        begin
            key_rd_reg <= key_mem[key_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + KEY_AW'(1);
        end
    end

    assign pair_ok = key_rd_reg.lead_seen && key_rd_reg.trail_seen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.drain_en && pair_ok)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.drain_en && pair_ok)
        begin
            out_key_reg   <= key_index_reg;
            lead_time_reg <= key_rd_reg.lead_min;
            width_reg     <= key_rd_reg.trail_min - key_rd_reg.lead_min;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_key      = out_key_reg;
    assign lead_time_fs = lead_time_reg;
    assign width_fs     = width_reg;

endmodule

// ----- rtl/tdc_inl_correct_hit_pairing_top.sv -----
// Converter hit processing with per-channel INL correction and edge pairing.
// One item is in flight at a time, stepped by a single sequencer; a drain is
// held while the previous result still waits in the output register. Each
// item passes the multi-step bin address (raw count mod bin count by
// reciprocal multiply) and the registered reads of the correction and key
// memories; a hit then adds the three-step Q8 time computation. After
// reset the key memory is swept, clearing every entry, before the first
// item is taken; register writes are accepted throughout.
// Correction words that were never loaded read as garbage, so load a
// channel's table completely before hits on that channel use it.
module tdc_inl_correct_hit_pairing_top #(
    parameter int CORR_BINS    = tdc_ihp_pkg::CORR_BINS_DEF,
    parameter int NUM_CHANNELS = tdc_ihp_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_KEYS     = tdc_ihp_pkg::NUM_KEYS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tdc_ihp_pkg::APB_AW-1:0]         paddr,
    input  logic [tdc_ihp_pkg::APB_DW-1:0]         pwdata,
    output logic [tdc_ihp_pkg::APB_DW-1:0]         prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [tdc_ihp_pkg::MODE_W-1:0]         mode,
    input  logic [tdc_ihp_pkg::CH_W-1:0]           channel,
    input  logic [tdc_ihp_pkg::BIN_W-1:0]          corr_bin,
    input  logic signed [tdc_ihp_pkg::CORR_W-1:0]  corr_value,
    input  logic                                   corr_last,
    input  logic [tdc_ihp_pkg::RAW_W-1:0]          raw_time,
    input  logic                                   leading,
    input  logic [tdc_ihp_pkg::KEY_W-1:0]          key_index,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [tdc_ihp_pkg::KEY_W-1:0]          out_key,
    output logic signed [tdc_ihp_pkg::TIME_W-1:0]  lead_time_fs,
    output logic signed [tdc_ihp_pkg::TIME_W-1:0]  width_fs
);
    import tdc_ihp_pkg::*;

    ihp_cmd_t          cmd;
    ihp_status_t       status;
    logic              use_correction;
    logic [BWID_W-1:0] bin_width_fs;

    tdc_ihp_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .use_correction (use_correction),
        .bin_width_fs   (bin_width_fs)
    );

    tdc_ihp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tdc_ihp_datapath #(
        .CORR_BINS    (CORR_BINS),
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_KEYS     (NUM_KEYS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .use_correction (use_correction),
        .bin_width_fs   (bin_width_fs),
        .mode           (mode),
        .channel        (channel),
        .corr_bin       (corr_bin),
        .corr_value     (corr_value),
        .corr_last      (corr_last),
        .raw_time       (raw_time),
        .leading        (leading),
        .key_index      (key_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_key        (out_key),
        .lead_time_fs   (lead_time_fs),
        .width_fs       (width_fs)
    );

endmodule
